@@ hw/rtl/ncpl_pkg.sv @@
// ----------------------------------------------------------------------------
// ncpl_pkg: shared types and constants for the nearest center pixel labeler
// Feature widths, register indexes, and small helpers.
// ----------------------------------------------------------------------------
package ncpl_pkg;

	localparam int MAX_CENTERS_DEF = 16;
	localparam int COORD_BITS_DEF  = 12;

	localparam int FEAT_W  = 24;
	localparam int NFEAT   = 5;
	localparam int SCALE_W = 16;
	localparam int SIZE_W  = 13;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 4;
	localparam int NUM_W   = 5;
	localparam int DIST_W  = 53;

	localparam logic [2:0] REG_NUM_CENTERS   = 3'd0;
	localparam logic [2:0] REG_COLOR_SCALE   = 3'd1;
	localparam logic [2:0] REG_SPATIAL_SCALE = 3'd2;
	localparam logic [2:0] REG_FRAME_ROWS    = 3'd3;
	localparam logic [2:0] REG_FRAME_COLS    = 3'd4;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	typedef logic [FEAT_W-1:0] feat_t;

	// Control from the sequencer to the divider.
	typedef struct packed {
		logic               start;
		logic [FEAT_W+16:0] dividend;
		logic [SCALE_W-1:0] divisor;
		logic [5:0]         steps;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [FEAT_W+16:0] quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/ncpl_divider.sv @@
// ----------------------------------------------------------------------------
// ncpl_divider: restoring divider, one quotient bit per cycle
// Computes dividend / divisor over req.steps low bits of the dividend.
// ----------------------------------------------------------------------------
module ncpl_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  ncpl_pkg::div_req_t req,
	output ncpl_pkg::div_rsp_t rsp
);
	import ncpl_pkg::*;

	localparam int DW = FEAT_W + 17;

	logic [DW-1:0]      quo_q;
	logic [SCALE_W:0]   rem_q;
	logic [SCALE_W-1:0] dsr_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SCALE_W+1:0] trial;

	assign trial = {rem_q, quo_q[DW-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend is pre-shifted so its top bits enter first.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend << (6'(DW) - req.steps);
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[SCALE_W+1]) begin
				rem_q <= trial[SCALE_W:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SCALE_W-1:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hw/rtl/nearest_center_pixel_labeler_top.sv @@
// ----------------------------------------------------------------------------
// nearest_center_pixel_labeler_top: nearest k-means center for one pixel
// Loads centers, then labels pixels with the index and color of the
// nearest center in a five-feature space.
// ----------------------------------------------------------------------------
// A load transaction passes through the load state ST_LOAD with busy high and
// yields no result. A classify transaction runs a small sequencer: two
// passes of a shared bit-serial divider normalize column and row, the
// states ST_SCLX and ST_SCLY scale them, then for each searched center a
// table read, five multiply-accumulate steps on a single multiplier and a
// compare form the squared distance, and three divider passes unscale the
// winning colors. The result appears for exactly one cycle with done high,
// in the first cycle with busy low; the receiver cannot stall it, so sample
// it then.
// Reading a center that was never loaded gives undefined output.
// ----------------------------------------------------------------------------
module nearest_center_pixel_labeler_top #(
	parameter int MAX_CENTERS = ncpl_pkg::MAX_CENTERS_DEF,
	parameter int COORD_BITS  = ncpl_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	output logic                       done,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [ncpl_pkg::CFG_W-1:0] cfg_data,
	input  logic                       command,
	input  logic [3:0]                 center_index,
	input  ncpl_pkg::feat_t            center_blue,
	input  ncpl_pkg::feat_t            center_green,
	input  ncpl_pkg::feat_t            center_red,
	input  ncpl_pkg::feat_t            center_xpos,
	input  ncpl_pkg::feat_t            center_ypos,
	input  logic [7:0]                 pixel_blue,
	input  logic [7:0]                 pixel_green,
	input  logic [7:0]                 pixel_red,
	input  logic [COORD_BITS-1:0]      pixel_row,
	input  logic [COORD_BITS-1:0]      pixel_col,
	output logic [7:0]                 out_blue,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_red,
	output logic [3:0]                 label
);
	import ncpl_pkg::*;

	localparam int IW = $clog2(MAX_CENTERS);
	localparam int AW = IW + 1;
	localparam int FW = FEAT_W + 17;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVC  = 4'd1;
	localparam logic [3:0] ST_DIVR  = 4'd2;
	localparam logic [3:0] ST_SCLX  = 4'd3;
	localparam logic [3:0] ST_SCLY  = 4'd4;
	localparam logic [3:0] ST_RD    = 4'd5;
	localparam logic [3:0] ST_DIST  = 4'd6;
	localparam logic [3:0] ST_CMP   = 4'd7;
	localparam logic [3:0] ST_BRD   = 4'd8;
	localparam logic [3:0] ST_UNS   = 4'd9;
	localparam logic [3:0] ST_LOAD  = 4'd10;

	// Configuration registers.
	logic [NUM_W-1:0]   num_q;
	logic [SCALE_W-1:0] cscale_q, sscale_q;
	logic [SIZE_W-1:0]  rows_q, cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q    <= NUM_W'(1);
			cscale_q <= SCALE_W'(256);
			sscale_q <= SCALE_W'(256);
			rows_q   <= SIZE_W'(480);
			cols_q   <= SIZE_W'(640);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_CENTERS:   num_q    <= cfg_data[NUM_W-1:0];
				REG_COLOR_SCALE:   cscale_q <= cfg_data;
				REG_SPATIAL_SCALE: sscale_q <= cfg_data;
				REG_FRAME_ROWS:    rows_q   <= cfg_data[SIZE_W-1:0];
				REG_FRAME_COLS:    cols_q   <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Center memory: one entry of five features per center, registered read.
	logic [NFEAT*FEAT_W-1:0] mem [MAX_CENTERS];
	logic [NFEAT*FEAT_W-1:0] rd_q;
	logic [IW-1:0]           rd_addr;
	logic                    wr_en;
	logic [NFEAT*FEAT_W-1:0] wr_data_q;
	logic [3:0]              wr_idx_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[IW'(wr_idx_q)] <= wr_data_q;
		rd_q <= mem[rd_addr];
	end

	// Sequencer state.
	logic [3:0]         st_q;
	logic [7:0]         pb_q, pg_q, pr_q;
	logic [COORD_BITS-1:0] prow_q, pcol_q;
	logic [15:0]        fx_q, fy_q;
	feat_t              feat_q [NFEAT];
	logic [IW-1:0]      ci_q, best_q;
	logic [AW-1:0]      n_q;
	logic [2:0]         k_q;
	logic [DIST_W-1:0]  acc_q, best_d_q;
	logic [1:0]         ch_q;
	logic [7:0]         ob_q, og_q, or_q;
	logic               done_q;
	logic               wr_pend_q;

	assign wr_en = wr_pend_q;

	div_req_t dreq;
	div_rsp_t drsp;

	ncpl_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic dstart_q;
	logic [FW-1:0] ddend_q;
	logic [SCALE_W-1:0] ddsr_q;
	logic [5:0] dsteps_q;
	assign dreq.start    = dstart_q;
	assign dreq.dividend = ddend_q;
	assign dreq.divisor  = ddsr_q;
	assign dreq.steps    = dsteps_q;

	// Shared multiplier: 25x25 operands.
	logic [FEAT_W:0]     mul_a, mul_b;
	logic [2*FEAT_W+1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	// Current feature difference for the distance pass.
	feat_t  cfeat;
	logic [FEAT_W:0] diff;
	always_comb begin
		cfeat = rd_q[k_q*FEAT_W +: FEAT_W];
		diff  = (feat_q[k_q] > cfeat) ? {1'b0, feat_q[k_q] - cfeat}
		                              : {1'b0, cfeat - feat_q[k_q]};
	end

	always_comb begin
		mul_a = diff;
		mul_b = diff;
		if (st_q == ST_SCLX) begin
			mul_a = {{(FEAT_W-15){1'b0}}, fx_q};
			mul_b = {{(FEAT_W-15){1'b0}}, sscale_q};
		end else if (st_q == ST_SCLY) begin
			mul_a = {{(FEAT_W-15){1'b0}}, fy_q};
			mul_b = {{(FEAT_W-15){1'b0}}, sscale_q};
		end
	end

	// Position fraction: divider result saturated; oversize coords saturate.
	logic [15:0] frac_sat;
	assign frac_sat = (|drsp.quotient[FW-1:16]) ? 16'hFFFF : drsp.quotient[15:0];

	logic [SIZE_W-1:0] csize, rsize;
	assign csize = cols_q;
	assign rsize = rows_q;

	logic pos_sat_c, pos_sat_r;
	assign pos_sat_c = (csize == '0) || (32'(pcol_q) >= 32'(csize));
	assign pos_sat_r = (rsize == '0) || (32'(prow_q) >= 32'(rsize));

	logic [SCALE_W-1:0] cdiv;
	assign cdiv = (cscale_q == '0) ? SCALE_W'(1) : cscale_q;

	feat_t bfeat;
	assign bfeat = rd_q[ch_q*FEAT_W +: FEAT_W];

	logic [7:0] uns_clamp;
	assign uns_clamp = (|drsp.quotient[FW-1:8]) ? 8'hFF : drsp.quotient[7:0];

	// Current center beats the best so far (ties keep the lower index).
	logic take_new;
	assign take_new = (ci_q == '0) || (acc_q < best_d_q);

	// In the compare cycle the read already targets the winner so far, so
	// the first unscale pass finds the winning entry in rd_q.
	always_comb begin
		rd_addr = ci_q;
		if (st_q == ST_CMP && !take_new)
			rd_addr = best_q;
		if (st_q == ST_BRD || st_q == ST_UNS)
			rd_addr = best_q;
	end

	logic [DIST_W-1:0] acc_nx;
	assign acc_nx = acc_q + DIST_W'(mul_p);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			done_q    <= 1'b0;
			dstart_q  <= 1'b0;
			wr_pend_q <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			dstart_q  <= 1'b0;
			wr_pend_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						if (command == CMD_LOAD) begin
							wr_pend_q <= (32'(center_index) < 32'(MAX_CENTERS));
							st_q      <= ST_LOAD;
						end else begin
							dstart_q <= 1'b1;
							ddend_q  <= FW'({pixel_col, 16'h0000});
							ddsr_q   <= {{(SCALE_W-SIZE_W){1'b0}},
							             (cols_q == '0) ? SIZE_W'(1) : cols_q};
							dsteps_q <= 6'(COORD_BITS + 17);
							st_q     <= ST_DIVC;
						end
					end
				end
				ST_LOAD: st_q <= ST_IDLE;
				ST_DIVC: begin
					// color features scaled by one multiply each
					feat_q[0] <= FEAT_W'(pb_q) * FEAT_W'(cscale_q);
					feat_q[1] <= FEAT_W'(pg_q) * FEAT_W'(cscale_q);
					feat_q[2] <= FEAT_W'(pr_q) * FEAT_W'(cscale_q);
					if (drsp.done) begin
						fx_q     <= pos_sat_c ? 16'hFFFF : frac_sat;
						dstart_q <= 1'b1;
						ddend_q  <= FW'({prow_q, 16'h0000});
						ddsr_q   <= {{(SCALE_W-SIZE_W){1'b0}},
						             (rows_q == '0) ? SIZE_W'(1) : rows_q};
						st_q     <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (drsp.done) begin
						fy_q <= pos_sat_r ? 16'hFFFF : frac_sat;
						st_q <= ST_SCLX;
					end
				end
				ST_SCLX: begin
					feat_q[3] <= FEAT_W'((mul_p[32:0] + 33'd32768) >> 16);
					st_q      <= ST_SCLY;
				end
				ST_SCLY: begin
					feat_q[4] <= FEAT_W'((mul_p[32:0] + 33'd32768) >> 16);
					ci_q <= '0;
					st_q <= ST_RD;
				end
				ST_RD: begin
					k_q   <= '0;
					acc_q <= '0;
					st_q  <= ST_DIST;
				end
				ST_DIST: begin
					acc_q <= acc_nx;
					if (k_q == 3'(NFEAT-1))
						st_q <= ST_CMP;
					else
						k_q <= k_q + 3'd1;
				end
				ST_CMP: begin
					if (take_new) begin
						best_d_q <= acc_q;
						best_q   <= ci_q;
					end
					if (AW'(ci_q) + AW'(1) >= n_q) begin
						ch_q <= '0;
						st_q <= ST_BRD;
					end else begin
						ci_q <= ci_q + IW'(1);
						st_q <= ST_RD;
					end
				end
				ST_BRD: begin
					dstart_q <= 1'b1;
					ddend_q  <= FW'(bfeat) + FW'(cdiv >> 1);
					ddsr_q   <= cdiv;
					dsteps_q <= 6'(FEAT_W + 1);
					st_q     <= ST_UNS;
				end
				ST_UNS: begin
					if (drsp.done) begin
						unique case (ch_q)
							2'd0: ob_q <= uns_clamp;
							2'd1: og_q <= uns_clamp;
							default: or_q <= uns_clamp;
						endcase
						if (ch_q == 2'd2) begin
							done_q <= 1'b1;
							st_q   <= ST_IDLE;
						end else begin
							ch_q <= ch_q + 2'd1;
							st_q <= ST_BRD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Input capture at acceptance.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			wr_idx_q  <= center_index;
			wr_data_q <= {center_ypos, center_xpos, center_red, center_green, center_blue};
			pb_q      <= pixel_blue;
			pg_q      <= pixel_green;
			pr_q      <= pixel_red;
			prow_q    <= pixel_row;
			pcol_q    <= pixel_col;
			if (num_q == '0)
				n_q <= AW'(1);
			else if (int'(num_q) > MAX_CENTERS)
				n_q <= AW'(MAX_CENTERS);
			else
				n_q <= AW'(num_q);
		end
	end

	assign busy      = (st_q != ST_IDLE);
	assign done      = done_q;
	assign out_blue  = ob_q;
	assign out_green = og_q;
	assign out_red   = or_q;
	assign label     = 4'(best_q);

endmodule
